FILE: hdl/vdi_pkg.sv
// shared types, constants and float-compare helpers for the vertex dedup indexer
// no dependencies; used by vdi_cell and vertex_dedup_indexer_unit
package vdi_pkg;

  localparam int WORD_W          = 32;
  localparam int VTX_WORDS       = 8;
  localparam int VTX_W           = WORD_W * VTX_WORDS;
  localparam int IDX_OUT_W       = 10;
  localparam int OUT_TDATA_W     = 16;
  localparam int TABLE_DEPTH_DEF = 1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN
  } vdi_state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic shift;
    logic wr_en;
  } cell_ctrl_t;

  function automatic logic word_is_nan(input logic [WORD_W-1:0] w);
    return (w & 32'h7FFF_FFFF) > 32'h7F80_0000;
  endfunction

  // float equality: signed zeros equal, nan never equal
  function automatic logic word_feq(input logic [WORD_W-1:0] a,
                                    input logic [WORD_W-1:0] b);
    logic eq;
    eq = 1'b0;
    if (word_is_nan(a) || word_is_nan(b)) begin
      eq = 1'b0;
    end else if (((a | b) & 32'h7FFF_FFFF) == 32'h0) begin
      eq = 1'b1;
    end else begin
      eq = (a == b);
    end
    return eq;
  endfunction

  function automatic logic vtx_match(input logic [VTX_W-1:0] a,
                                     input logic [VTX_W-1:0] b);
    logic m;
    m = 1'b1;
    for (int k = 0; k < VTX_WORDS; k++) begin
      m = m & word_feq(a[k*WORD_W +: WORD_W], b[k*WORD_W +: WORD_W]);
    end
    return m;
  endfunction

endpackage

FILE: hdl/vdi_cell.sv
// one table cell: holds one unique vertex and a hit bit that shifts toward cell 0
// depends on vdi_pkg
module vdi_cell #(
  parameter int IDX = 0,
  parameter int IW  = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vdi_pkg::cell_ctrl_t       ctrl,
  input  logic [vdi_pkg::VTX_W-1:0] key,
  input  logic [IW-1:0]             wr_idx,
  input  logic [IW-1:0]             count,
  input  logic                      hit_in,
  output logic                      hit_out
);
  import vdi_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [VTX_W-1:0] entry_r;
  logic             hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (wr_idx == MY_IDX)) begin
      entry_r <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.load) begin
      hit_r <= (MY_IDX < count) && vtx_match(entry_r, key);
    end else if (ctrl.shift) begin
      hit_r <= hit_in;
    end
  end

  assign hit_out = hit_r;

endmodule

FILE: hdl/vertex_dedup_indexer_unit.sv
// out_tvalid rises once the hit bits shifting toward cell 0 bring a match at index j to cell 0,
// or once every valid entry has passed cell 0 for a new or dropped vertex; later while out_tready is low
// one vertex at a time: the next beat is taken only after the last result is registered
// reset: synchronous active-low rst_n empties the table count and drops any pending beat
// start_mesh empties the table too; stored entries are never cleared, only the count
// top level of the vertex dedup indexer, depends on vdi_pkg and vdi_cell
module vertex_dedup_indexer_unit #(
  parameter int TABLE_DEPTH = vdi_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input vertex channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z (32 bits each)
  input  logic [vdi_pkg::VTX_W-1:0]       in_tdata,
  // start_mesh
  input  logic [0:0]                      in_tuser,
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // vertex_index (10 bits), zero padded to 16
  output logic [vdi_pkg::OUT_TDATA_W-1:0] out_tdata,
  // is_new, overflow
  output logic [1:0]                      out_tuser
);
  import vdi_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] FULL_CNT = IW'(TABLE_DEPTH);

  vdi_state_t state_r, state_nxt;

  logic [VTX_W-1:0]     key_r, key_nxt;
  logic [IW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        scan_idx_r, scan_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0] out_idx_r, out_idx_nxt;
  logic                 out_new_r, out_new_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  cell_ctrl_t           ctrl;
  logic [TABLE_DEPTH:0] hit_link;
  logic                 hit0;
  logic                 table_full;
  logic                 decide;
  logic                 slot_free;
  logic                 in_beat;

  // hit bits leave the chain at cell 0; nothing enters past the last cell
  assign hit_link[TABLE_DEPTH] = 1'b0;
  assign hit0                  = hit_link[0];

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      vdi_cell #(
        .IDX (g),
        .IW  (IW)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .key     (key_r),
        .wr_idx  (count_r),
        .count   (count_r),
        .hit_in  (hit_link[g+1]),
        .hit_out (hit_link[g])
      );
    end
  endgenerate

  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign table_full = (count_r == FULL_CNT);
  // scan ends on the first hit, or once every valid entry has passed cell 0
  assign decide     = (state_r == ST_SCAN) && (hit0 || (scan_idx_r == count_r));
  // output register takes a new result when empty or being drained this cycle
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_ovf_nxt   = out_ovf_r;
    ctrl          = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          key_nxt      = in_tdata;
          scan_idx_nxt = '0;
          if (in_tuser[0]) begin
            count_nxt = '0;
          end
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // every cell compares its entry against the key at once
        ctrl.load = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!decide) begin
          ctrl.shift   = 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (hit0) begin
            out_idx_nxt = IDX_OUT_W'(scan_idx_r);
            out_new_nxt = 1'b0;
            out_ovf_nxt = 1'b0;
          end else if (table_full) begin
            // no match and no room: vertex dropped
            out_idx_nxt = '0;
            out_new_nxt = 1'b0;
            out_ovf_nxt = 1'b1;
          end else begin
            // append at the tail cell
            ctrl.wr_en  = 1'b1;
            count_nxt   = count_r + 1'b1;
            out_idx_nxt = IDX_OUT_W'(count_r);
            out_new_nxt = 1'b1;
            out_ovf_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    scan_idx_r <= scan_idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_new_r  <= out_new_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_idx_r);
  assign out_tuser  = {out_ovf_r, out_new_r};

`ifndef ASSERT_OFF
  // the table count never runs past the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("table count beyond depth");

  // a result is never both new and dropped
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("is_new and overflow both set");

  // an append grows the count by exactly one
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_en |=> (count_r == $past(count_r) + 1'b1))
    else $error("append did not advance count");

  // the scan never walks past the valid entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_idx_r <= count_r))
    else $error("scan index beyond count");
`endif

endmodule
